[hw/rtl/bdlp_pkg.sv]
// Package for the button debounce and long-press block.
// Holds the item and configuration types, register indexes and button positions.
// No dependencies.
`default_nettype none

package bdlp_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam int B_STOP   = 0;
  localparam int B_UP     = 1;
  localparam int B_DOWN   = 2;
  localparam int B_LEFT   = 3;
  localparam int B_RIGHT  = 4;
  localparam int B_MANUAL = 5;
  localparam int B_AUTO   = 6;
  localparam int B_ANCHOR = 7;

  localparam logic [NUM_BUTTONS-1:0] MODE_MASK = 8'b1110_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_COMBO_HOLD = 2'd2
  } reg_index_t;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] COMBO_HOLD_RESET = 16'd3000;

  typedef struct packed {
    logic [CFG_BITS-1:0] settle_ms;
    logic [CFG_BITS-1:0] hold_ms;
    logic [CFG_BITS-1:0] combo_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] raw_mask;
    logic [31:0]            now_ms;
  } in_item_t;

  typedef struct packed {
    logic stop_requested;
    logic combo_request;
    logic manual_request;
    logic auto_request;
    logic anchor_request;
    logic thrust_up_held;
    logic thrust_down_held;
    logic steer_left_held;
    logic steer_right_held;
    logic anchor_held;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/bdlp_cfg.sv]
// Configuration registers of the button debounce block.
// Depends on bdlp_pkg for the register indexes and reset values.
`default_nettype none

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  output cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ms     <= DEBOUNCE_RESET;
      cfg.hold_ms       <= LONG_PRESS_RESET;
      cfg.combo_hold_ms <= COMBO_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg.settle_ms     <= cfg_data;
        REG_LONG_PRESS: cfg.hold_ms       <= cfg_data;
        REG_COMBO_HOLD: cfg.combo_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bdlp_core.sv]
// Debounce, press timing and combo state with the result logic for one item.
// Depends on bdlp_pkg for the item, configuration types and button positions.
`default_nettype none

module bdlp_core
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  typedef logic [TIME_BITS-1:0] tstamp_t;

  logic [NUM_BUTTONS-1:0] last_raw;
  tstamp_t                last_change;
  logic [NUM_BUTTONS-1:0] stable_mask;
  tstamp_t                press_start [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] reported;
  tstamp_t                combo_start;
  logic                   combo_reported;

  tstamp_t                now;
  tstamp_t                last_change_next;
  tstamp_t                deb_elapsed;
  logic                   raw_diff;
  logic [NUM_BUTTONS-1:0] stable_next;
  logic [NUM_BUTTONS-1:0] changed;
  tstamp_t                press_start_next [NUM_BUTTONS];
  tstamp_t                press_elapsed [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] rep_base;
  logic [NUM_BUTTONS-1:0] hit;
  logic [NUM_BUTTONS-1:0] reported_next;
  logic                   both;
  logic                   cs_zero;
  tstamp_t                combo_start_next;
  tstamp_t                combo_elapsed;
  logic                   combo_hit;
  logic                   combo_reported_next;

  always_comb begin
    now              = item.now_ms[TIME_BITS-1:0];
    raw_diff         = item.raw_mask != last_raw;
    last_change_next = raw_diff ? now : last_change;
    deb_elapsed      = raw_diff ? '0 : tstamp_t'(now - last_change);
    stable_next      = (deb_elapsed >= tstamp_t'(cfg.settle_ms)) ? item.raw_mask
                                                                  : stable_mask;
    changed          = stable_mask ^ stable_next;

    for (int b = 0; b < NUM_BUTTONS; b++) begin
      press_start_next[b] = changed[b] ? (stable_next[b] ? now : '0) : press_start[b];
      press_elapsed[b]    = changed[b] ? '0 : tstamp_t'(now - press_start[b]);
      rep_base[b]         = changed[b] ? 1'b0 : reported[b];
      hit[b]              = stable_next[b] && !rep_base[b] && (press_start_next[b] != '0)
                            && (press_elapsed[b] >= tstamp_t'(cfg.hold_ms));
    end
    reported_next = rep_base | (hit & MODE_MASK);

    both             = stable_next[B_UP] && stable_next[B_DOWN];
    cs_zero          = combo_start == '0;
    combo_start_next = both ? (cs_zero ? now : combo_start) : '0;
    combo_elapsed    = cs_zero ? '0 : tstamp_t'(now - combo_start);
    combo_hit        = both && !combo_reported
                       && (combo_elapsed >= tstamp_t'(cfg.combo_hold_ms));
    combo_reported_next = both && (combo_reported || combo_hit);

    result.stop_requested   = stable_next[B_STOP];
    result.combo_request    = combo_hit;
    result.manual_request   = hit[B_MANUAL];
    result.auto_request     = hit[B_AUTO];
    result.anchor_request   = hit[B_ANCHOR];
    result.thrust_up_held   = stable_next[B_UP];
    result.thrust_down_held = stable_next[B_DOWN];
    result.steer_left_held  = stable_next[B_LEFT];
    result.steer_right_held = stable_next[B_RIGHT];
    result.anchor_held      = stable_next[B_ANCHOR];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw       <= '0;
      last_change    <= '0;
      stable_mask    <= '0;
      reported       <= '0;
      combo_start    <= '0;
      combo_reported <= 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        press_start[b] <= '0;
      end
    end else if (step) begin
      last_raw       <= item.raw_mask;
      last_change    <= last_change_next;
      stable_mask    <= stable_next;
      reported       <= reported_next;
      combo_start    <= combo_start_next;
      combo_reported <= combo_reported_next;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        press_start[b] <= press_start_next[b];
      end
    end
  end

  a_stable_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(stable_mask))
    else $error("stable mask moved without an item");

  a_combo_needs_both: assert property (@(posedge clk) disable iff (rst)
    step && combo_hit |=> combo_reported && stable_mask[B_UP] && stable_mask[B_DOWN])
    else $error("combo fired without both thrust buttons held");

  a_long_press_once: assert property (@(posedge clk) disable iff (rst)
    step && hit[B_MANUAL] |=> reported[B_MANUAL] && stable_mask[B_MANUAL])
    else $error("manual long press not latched as reported");

  a_combo_clear: assert property (@(posedge clk) disable iff (rst)
    !(stable_mask[B_UP] && stable_mask[B_DOWN]) |-> !combo_reported && combo_start == '0)
    else $error("combo state left over after thrust release");

endmodule

`default_nettype wire

[hw/rtl/button_debounce_long_press.sv]
// Top level of the button debounce and long-press block: input and result registers.
// Depends on bdlp_pkg, bdlp_cfg and bdlp_core.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    in_item  (raw_mask, now_ms)
//  out      out_valid / out_ready  out_item (ten request and held bits)
//  cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high. An accepted item goes
// through the input register and the result register; a stall can hold it between.
// The item is held in the input register and processed combinationally into the
// result register; the state update is the combinational debounce and timer logic.
// A stalled result holds the item in the input register; in_ready stays high
// while that register is empty. Reset clears both valid flags and the core state.
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_item_t                in_item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_item_t                    out_item,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data
);

  cfg_t      cfg;
  logic      in_full;
  in_item_t  held;
  logic      step;
  out_item_t result;

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdlp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire
